@@ rtl/u2d_pkg.sv @@
// Shared types and constants for the 128-bit binary to decimal digit converter.
package u2d_pkg;

    localparam int VALUE_W   = 128;
    localparam int HALF_W    = 64;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 39;
    localparam int BCD_W     = DIGITS * DIGIT_W;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int IDX_W     = $clog2(DIGITS);
    localparam int CNT_W     = $clog2(DIGITS + 1);

    // Digits of five or more get three added before each doubling.
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADJ_ADD   = DIGIT_W'(3);

    typedef struct packed {
        logic [HALF_W-1:0] value_high;
        logic [HALF_W-1:0] value_low;
    } t_in;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_out;

endpackage

@@ rtl/u128_to_decimal_digits.sv @@
// Top level: converts a 128-bit unsigned word to decimal digits, most significant first.
//
//  Channel   Ports                    Handshake
//  -------   ----------------------   -----------------------------------------
//  input     i_in, start, busy        word taken when start is high, busy low
//  result    o_out, o_strobe          one digit word per cycle with o_strobe high
//
// A word is loaded, then goes through shift-and-adjust (one input bit a cycle
// through the shared digit adjust unit), then its digits are emitted one per cycle,
// at most 39 of them. Digits come out in consecutive cycles and the last one
// carries last. Reset is synchronous and returns the sequencer to idle. The
// receiver cannot stall; each digit is valid for one cycle.
module u128_to_decimal_digits (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  u2d_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_strobe,
    output u2d_pkg::t_out o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [u2d_pkg::VALUE_W-1:0]     r_bin;
    logic [u2d_pkg::BCD_W-1:0]       r_bcd;
    logic [u2d_pkg::BCD_W-1:0]       n_bcd;
    logic [u2d_pkg::BCD_W-1:0]       adj;
    logic [u2d_pkg::BIT_CNT_W-1:0]   r_bit;
    logic [u2d_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic [u2d_pkg::IDX_W-1:0]       r_idx;
    logic                            r_strobe;
    u2d_pkg::t_out                   r_out;

    // Shared digit adjust unit: add three to every digit of five or more.
    always_comb begin
        for (int d = 0; d < u2d_pkg::DIGITS; d++) begin
            if (r_bcd[d*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] >= u2d_pkg::ADJ_LIMIT) begin
                adj[d*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
                    r_bcd[d*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] + u2d_pkg::ADJ_ADD;
            end else begin
                adj[d*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
                    r_bcd[d*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W];
            end
        end
        n_bcd = {adj[u2d_pkg::BCD_W-2:0], r_bin[u2d_pkg::VALUE_W-1]};
    end

    // The value at most doubles plus one per step, so the significant digit count grows
    // by at most one; only the digit just above the current count needs a look.
    always_comb begin
        n_cnt = r_cnt;
        if (r_cnt < u2d_pkg::CNT_W'(u2d_pkg::DIGITS)) begin
            if (n_bcd[r_cnt[u2d_pkg::IDX_W-1:0]*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] != '0) begin
                n_cnt = r_cnt + u2d_pkg::CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (r_bit == '0) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_bin <= {i_in.value_high, i_in.value_low};
                r_bcd <= '0;
                r_cnt <= '0;
                r_bit <= u2d_pkg::BIT_CNT_W'(u2d_pkg::VALUE_W - 1);
            end
            S_CONV: begin
                r_bcd <= n_bcd;
                r_bin <= {r_bin[u2d_pkg::VALUE_W-2:0], 1'b0};
                r_cnt <= n_cnt;
                r_bit <= r_bit - u2d_pkg::BIT_CNT_W'(1);
                // A zero value still yields one digit, at index zero.
                if (n_cnt == '0) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= u2d_pkg::IDX_W'(n_cnt - u2d_pkg::CNT_W'(1));
                end
            end
            S_EMIT: begin
                r_out.digit <= r_bcd[r_idx*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W];
                r_out.last  <= (r_idx == '0);
                r_idx       <= r_idx - u2d_pkg::IDX_W'(1);
            end
            default: begin
                r_bit <= r_bit;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_out    = r_out;

endmodule

@@ rtl/u2d_checker.sv @@
// Port-level checker for the decimal digit converter, with its bind statement.
module u2d_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_strobe,
    input u2d_pkg::t_out o_out
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a word was taken");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_out.digit <= 4'd9)
        else $error("digit out of decimal range");

    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_out.last |=> o_strobe)
        else $error("gap before the last digit");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_out.last |=> !o_strobe)
        else $error("digit after the last digit");

    a_no_early_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_strobe)
        else $error("digit shown right after a word was taken");

endmodule

bind u128_to_decimal_digits u2d_checker u_u2d_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_out   (o_out)
);
